FILE: hw/rtl/i2cmbe_pkg.sv
// Shared constants for the I2C master bit engine: phase codes, command kinds, register map.
`timescale 1ns / 1ps
`default_nettype none

package i2cmbe_pkg;

    localparam int TICK_BITS  = 10;
    localparam int LIMIT_BITS = 8;
    localparam int PHASE_BITS = 4;
    localparam int KIND_BITS  = 3;
    localparam int CFG_IDX_BITS = 3;

    // Sequencer phases.
    localparam logic [PHASE_BITS-1:0] PH_IDLE   = 4'd0;
    localparam logic [PHASE_BITS-1:0] PH_START  = 4'd1;
    localparam logic [PHASE_BITS-1:0] PH_STOP   = 4'd2;
    localparam logic [PHASE_BITS-1:0] PH_WLOW   = 4'd3;
    localparam logic [PHASE_BITS-1:0] PH_WHIGH  = 4'd4;
    localparam logic [PHASE_BITS-1:0] PH_AFIRST = 4'd5;
    localparam logic [PHASE_BITS-1:0] PH_ADELAY = 4'd6;
    localparam logic [PHASE_BITS-1:0] PH_AHOLD  = 4'd7;
    localparam logic [PHASE_BITS-1:0] PH_RPRE   = 4'd8;
    localparam logic [PHASE_BITS-1:0] PH_RHIGH1 = 4'd9;
    localparam logic [PHASE_BITS-1:0] PH_RHIGH2 = 4'd10;
    localparam logic [PHASE_BITS-1:0] PH_RLOW   = 4'd11;
    localparam logic [PHASE_BITS-1:0] PH_RACK   = 4'd12;

    // Command kinds.
    localparam logic [KIND_BITS-1:0] KIND_START = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_STOP  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_WRITE = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_ACK   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_READ  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_TICKS     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WRITE_HALF     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_READ_HALF      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_POLL_TICKS     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACK_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACK_HOLD_TICKS = 3'd5;

    localparam logic [TICK_BITS-1:0]  EDGE_TICKS_RST = 10'd4;
    localparam logic [TICK_BITS-1:0]  WRITE_HALF_RST = 10'd2;
    localparam logic [TICK_BITS-1:0]  READ_HALF_RST  = 10'd20;
    localparam logic [TICK_BITS-1:0]  POLL_TICKS_RST = 10'd2;
    localparam logic [LIMIT_BITS-1:0] ACK_LIMIT_RST  = 8'd250;
    localparam logic [TICK_BITS-1:0]  ACK_HOLD_RST   = 10'd20;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // A hold of zero ticks behaves as one tick.
    function automatic logic [TICK_BITS-1:0] hold_ticks(input logic [TICK_BITS-1:0] n);
        hold_ticks = (n == '0) ? {{(TICK_BITS-1){1'b0}}, 1'b1} : n;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_master_bit_engine_unit.sv
// I2C master bit engine: tick-driven start/stop/write/ack-wait/read sequencer.
// Result: the result beat for a tick is registered when the tick beat is taken and appears in the next cycle.
// Throughput: one tick beat per clock while the output is not stalled; the phase register and the result register
// form the only stage, and the result register frees as soon as its beat is taken.
// Reset: asynchronous, active low; SCL and SDA released high, sequencer idle,
// configuration registers back to their default tick counts.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine_unit
    import i2cmbe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Tick input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // cmd_valid, tx_byte[7:0], send_ack, sda_in, zero pad
    input  wire logic [2:0]  s_axis_tuser,  // kind[2:0]
    // Line state output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // scl, sda_out, busy_res, done_res, rx_byte[7:0],
                                            // ack_error, zero pad
    // Configuration
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [TICK_BITS-1:0]    cfg_data
);

    // Configuration registers
    logic [TICK_BITS-1:0]  edge_ticks_reg;
    logic [TICK_BITS-1:0]  write_half_reg;
    logic [TICK_BITS-1:0]  read_half_reg;
    logic [TICK_BITS-1:0]  poll_ticks_reg;
    logic [LIMIT_BITS-1:0] ack_limit_reg;
    logic [TICK_BITS-1:0]  ack_hold_reg;

    // Sequencer state
    logic [PHASE_BITS-1:0] phase_reg,  phase_next;
    logic [TICK_BITS-1:0]  wait_reg,   wait_next;
    logic [3:0]            bit_reg,    bit_next;
    logic [7:0]            shift_reg,  shift_next;
    logic [LIMIT_BITS-1:0] poll_reg,   poll_next;
    logic                  ackc_reg,   ackc_next;
    logic                  scl_reg,    scl_next;
    logic                  sda_reg,    sda_next;
    logic                  err_reg,    err_next;
    logic [7:0]            rx_reg,     rx_next;
    logic                  done_next;

    // Result register
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;

    // Input fields
    logic                  in_cmd_valid;
    logic [KIND_BITS-1:0]  in_kind;
    logic [7:0]            in_tx_byte;
    logic                  in_send_ack;
    logic                  in_sda;
    logic                  s_fire;

    assign in_cmd_valid = s_axis_tdata[0];
    assign in_tx_byte   = s_axis_tdata[8:1];
    assign in_send_ack  = s_axis_tdata[9];
    assign in_sda       = s_axis_tdata[10];
    assign in_kind      = s_axis_tuser;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_ticks_reg <= EDGE_TICKS_RST;
            write_half_reg <= WRITE_HALF_RST;
            read_half_reg  <= READ_HALF_RST;
            poll_ticks_reg <= POLL_TICKS_RST;
            ack_limit_reg  <= ACK_LIMIT_RST;
            ack_hold_reg   <= ACK_HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EDGE_TICKS:     edge_ticks_reg <= cfg_data;
                REG_WRITE_HALF:     write_half_reg <= cfg_data;
                REG_READ_HALF:      read_half_reg  <= cfg_data;
                REG_POLL_TICKS:     poll_ticks_reg <= cfg_data;
                REG_ACK_LIMIT:      ack_limit_reg  <= cfg_data[LIMIT_BITS-1:0];
                REG_ACK_HOLD_TICKS: ack_hold_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        logic [TICK_BITS-1:0] wait_dec;
        logic                 do_poll;
        logic                 do_adv;
        logic                 put_bit;
        logic [3:0]           bit_inc;

        phase_next = phase_reg;
        wait_next  = wait_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        ackc_next  = ackc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        err_next   = err_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        do_poll    = 1'b0;
        do_adv     = 1'b0;
        put_bit    = 1'b0;
        wait_dec   = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;
        bit_inc    = bit_reg + 4'd1;

        if (phase_reg == PH_IDLE)
        begin
            if (in_cmd_valid)
            begin
                unique case (in_kind)
                    KIND_START:
                    begin
                        bit_next   = '0;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        wait_next  = hold_ticks(edge_ticks_reg);
                        phase_next = PH_START;
                    end
                    KIND_STOP:
                    begin
                        bit_next   = '0;
                        sda_next   = 1'b0;
                        scl_next   = 1'b1;
                        wait_next  = hold_ticks(edge_ticks_reg);
                        phase_next = PH_STOP;
                    end
                    KIND_WRITE:
                    begin
                        bit_next   = '0;
                        scl_next   = 1'b0;
                        sda_next   = in_tx_byte[7];
                        shift_next = {in_tx_byte[6:0], 1'b0};
                        wait_next  = hold_ticks(write_half_reg);
                        phase_next = PH_WLOW;
                    end
                    KIND_ACK:
                    begin
                        bit_next   = '0;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        poll_next  = '0;
                        err_next   = 1'b0;
                        phase_next = PH_AFIRST;
                    end
                    KIND_READ:
                    begin
                        bit_next   = '0;
                        ackc_next  = in_send_ack;
                        shift_next = '0;
                        sda_next   = 1'b1;
                        scl_next   = 1'b0;
                        wait_next  = hold_ticks(read_half_reg);
                        phase_next = PH_RPRE;
                    end
                    default: ;
                endcase
            end
        end
        else if (phase_reg == PH_AFIRST)
        begin
            do_poll = 1'b1;
        end
        else
        begin
            wait_next = wait_dec;
            do_adv    = (wait_dec == '0);
        end

        if (do_adv)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_STOP:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_WLOW:
                begin
                    scl_next   = 1'b1;
                    wait_next  = hold_ticks(write_half_reg);
                    phase_next = PH_WHIGH;
                end
                PH_WHIGH:
                begin
                    scl_next = 1'b0;
                    bit_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        put_bit = 1'b1;
                    end
                end
                PH_ADELAY:
                begin
                    do_poll = 1'b1;
                end
                PH_AHOLD:
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_RPRE:
                begin
                    scl_next   = 1'b1;
                    wait_next  = hold_ticks(read_half_reg);
                    phase_next = PH_RHIGH1;
                end
                PH_RHIGH1:
                begin
                    shift_next = {shift_reg[6:0], in_sda};
                    wait_next  = hold_ticks(read_half_reg);
                    phase_next = PH_RHIGH2;
                end
                PH_RHIGH2:
                begin
                    scl_next   = 1'b0;
                    wait_next  = hold_ticks(read_half_reg);
                    phase_next = PH_RLOW;
                end
                PH_RLOW:
                begin
                    bit_next = bit_inc;
                    scl_next = 1'b1;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        sda_next   = !ackc_reg;
                        wait_next  = hold_ticks(write_half_reg);
                        phase_next = PH_RACK;
                    end
                    else
                    begin
                        wait_next  = hold_ticks(read_half_reg);
                        phase_next = PH_RHIGH1;
                    end
                end
                PH_RACK:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    rx_next    = shift_reg;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Next bit of a byte write: drive the MSB with SCL low.
        if (put_bit)
        begin
            scl_next   = 1'b0;
            sda_next   = shift_reg[7];
            shift_next = {shift_reg[6:0], 1'b0};
            wait_next  = hold_ticks(write_half_reg);
            phase_next = PH_WLOW;
        end

        // One SDA sample while waiting for the slave to acknowledge.
        if (do_poll)
        begin
            if (!in_sda)
            begin
                scl_next   = 1'b0;
                wait_next  = hold_ticks(ack_hold_reg);
                phase_next = PH_AHOLD;
            end
            else if (poll_reg >= ack_limit_reg)
            begin
                err_next   = 1'b1;
                sda_next   = 1'b0;
                scl_next   = 1'b1;
                wait_next  = hold_ticks(edge_ticks_reg);
                phase_next = PH_STOP;
            end
            else
            begin
                poll_next  = poll_reg + 1'b1;
                wait_next  = hold_ticks(poll_ticks_reg);
                phase_next = PH_ADELAY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            poll_reg  <= '0;
            ackc_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            err_reg   <= 1'b0;
            rx_reg    <= '0;
        end
        else if (s_fire)
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            ackc_reg  <= ackc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            err_reg   <= err_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_data_reg <= {3'b000, err_next, rx_next, done_next,
                             (phase_next != PH_IDLE), sda_next, scl_next};
        end
    end

    // Every phase that counts ticks must hold a nonzero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE && phase_reg != PH_AFIRST) |-> (wait_reg != '0))
        else $error("tick counter empty in a counting phase");

    // The bit counter never passes one byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    // A pending result beat reflects the sequencer state it was built from.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == (phase_reg != PH_IDLE)
                           && m_axis_tdata[0] == scl_reg && m_axis_tdata[1] == sda_reg))
        else $error("result beat out of step with sequencer state");

    // A finishing tick leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> !m_axis_tdata[2])
        else $error("done flagged while still busy");

endmodule

`default_nettype wire
